FILE: rtl/core/vde_pkg.sv
// vde_pkg: shared widths, constants and the final-sum struct for the vector distance engine
// no dependencies; imported by every module of the engine
`timescale 1ns / 1ps
`default_nettype none
package vde_pkg;

   // running sum widths
   localparam int SQ_W   = 45;
   localparam int DOT_W  = 44;
   localparam int NORM_W = 43;
   localparam int DIST_W = 44;

   // cosine result in unsigned q2.16
   localparam int Q_W = 18;
   localparam logic [Q_W-1:0] Q_ONE = 18'd65536;
   localparam logic [Q_W-1:0] Q_MAX = 18'd131072;

   // k = 131073 - 2q, and its square
   localparam int K_W  = 20;
   localparam int KM_W = 18;
   localparam int KK_W = 35;
   localparam logic signed [K_W-1:0] K_BASE = 20'sd131073;

   // shift-add multiplier operands
   localparam int MUL_A_W   = 86;
   localparam int MUL_B_W   = 44;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = 6;

   localparam int PROD_W = 2 * NORM_W;
   localparam int DSQ_W  = 2 * DOT_W;
   localparam int LSQ_SH = 34;
   localparam int LSQ_W  = DSQ_W + LSQ_SH;

   typedef struct packed {
      logic [SQ_W-1:0]   sq;
      logic [DOT_W-1:0]  dot;
      logic [NORM_W-1:0] na;
      logic [NORM_W-1:0] nb;
      logic              ovf;
   } sums_type;

endpackage
`default_nettype wire

FILE: rtl/core/vector_distance_engine.sv
// vector_distance_engine: top level, lane array, merge stage, cosine unit and output register
// depends on vde_pkg, vde_lane, vde_merge, vde_cosine
`timescale 1ns / 1ps
`default_nettype none
// Streams two signed vectors as up to four element pairs per request and keeps the sum of
// squared differences, the dot product and both squared norms in running sums. A request with
// tlast closes the pair and gives one response: with metric 0 the squared euclidean distance
// (saturated to 44 bits), with metric 1 the cosine distance 1 - dot/(|a|*|b|) in unsigned
// q2.16 rounded to nearest, or exactly 1.0 with zero_norm set when a norm is zero. Elements
// past MAX_DIM in one pair are dropped and flag overflow. One request is taken every cycle while no
// closing request is held; the lane multipliers and the merge adder are one stage each. The squared
// euclidean response passes through the lane registers and then the output register. A cosine
// response comes from a bisection over q driven by one shift-add multiplier: the products
// na*nb and dot*dot as setup, then up to 19 tests. Requests of the next pair are still
// taken while it runs; only its closing request waits for the cosine unit. The response sits
// in an output register, so a stalled response stops only closing requests.
module vector_distance_engine
   import vde_pkg::*;
#(
   parameter int MAX_DIM    = 4096,
   parameter int LANES      = 4,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // config
   input  wire logic                csr_wr_en,
   input  wire logic                csr_wr_data,     // metric: 0 squared l2, 1 cosine
   // requests
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [((8*ELEM_WIDTH+3+7)/8)*8-1:0] req_tdata, // a0..a3, b0..b3, lanes_valid
   input  wire logic                req_tlast,       // last request of the vector pair
   // responses
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [47:0]              rsp_tdata,       // distance
   output logic [1:0]               rsp_tuser        // zero_norm, overflow
);

   localparam int FIELD_LANES = 4;
   localparam int NUM_LANES   = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
   localparam int CNT_W       = $clog2(MAX_DIM + 1);
   localparam int CW          = CNT_W + 3;
   localparam int NV_LSB      = 2 * FIELD_LANES * ELEM_WIDTH;

   // configuration
   logic metric_ff, metric_in;

   // element count and stage one control
   logic [CNT_W-1:0] count_ff, count_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_last_ff, s1_last_in;
   logic             s1_ovf_ff, s1_ovf_in;
   logic             s1_go, accept;

   logic [2:0]       n_sat;
   logic [CW-1:0]    n_w, room_w, take_w;

   // lane outputs
   logic [SQ_W-1:0]   lane_sq  [NUM_LANES];
   logic [DOT_W-1:0]  lane_dot [NUM_LANES];
   logic [NORM_W-1:0] lane_na  [NUM_LANES];
   logic [NORM_W-1:0] lane_nb  [NUM_LANES];

   sums_type fin;

   // cosine unit
   logic           cos_start, cos_idle, cos_valid, cos_ack, cos_zero;
   logic [Q_W-1:0] cos_q;
   logic           ovf_pend_ff, ovf_pend_in;

   // output register
   logic              out_free;
   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic              out_zero_ff, out_zero_in;
   logic              out_ovf_ff, out_ovf_in;
   logic              l2_load;

   assign out_free   = !out_valid_ff || rsp_tready;
   // closing request moves on only when the path to the response is free
   assign s1_go      = s1_valid_ff && (!s1_last_ff ||
                       (metric_ff ? cos_idle : (out_free && !cos_valid)));
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // lane count clamp and MAX_DIM budget
   always_comb begin
      n_sat  = req_tdata[NV_LSB +: 3];
      if (n_sat > 3'(NUM_LANES)) begin
         n_sat = 3'(NUM_LANES);
      end
      n_w    = CW'(n_sat);
      room_w = CW'(MAX_DIM) - CW'(count_ff);
      take_w = (n_w < room_w) ? n_w : room_w;
   end

   genvar gi;
   generate
      for (gi = 0; gi < NUM_LANES; gi++) begin : g_lane
         vde_lane #(
            .ELEM_WIDTH (ELEM_WIDTH)
         ) u_lane (
            .clock  (clock),
            .load   (accept),
            .enable (take_w > CW'(gi)),
            .a      (req_tdata[gi*ELEM_WIDTH +: ELEM_WIDTH]),
            .b      (req_tdata[(FIELD_LANES+gi)*ELEM_WIDTH +: ELEM_WIDTH]),
            .sq_ff  (lane_sq[gi]),
            .dot_ff (lane_dot[gi]),
            .na_ff  (lane_na[gi]),
            .nb_ff  (lane_nb[gi])
         );
      end
   endgenerate

   vde_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .go       (s1_go),
      .last     (s1_last_ff),
      .ovf      (s1_ovf_ff),
      .lane_sq  (lane_sq),
      .lane_dot (lane_dot),
      .lane_na  (lane_na),
      .lane_nb  (lane_nb),
      .fin      (fin)
   );

   assign cos_start = s1_go && s1_last_ff && metric_ff;
   assign l2_load   = s1_go && s1_last_ff && !metric_ff;
   assign cos_ack   = cos_valid && out_free;

   vde_cosine u_cosine (
      .clock     (clock),
      .reset     (reset),
      .start     (cos_start),
      .sums      (fin),
      .res_ack   (cos_ack),
      .idle      (cos_idle),
      .res_valid (cos_valid),
      .res_q     (cos_q),
      .res_zero  (cos_zero)
   );

   always_comb begin
      metric_in = csr_wr_en ? csr_wr_data : metric_ff;

      // count restarts after the closing request
      count_in = count_ff;
      if (accept) begin
         count_in = req_tlast ? '0 : CNT_W'(CW'(count_ff) + take_w);
      end

      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_ovf_in   = s1_ovf_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_tlast;
         s1_ovf_in   = n_w > room_w;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      ovf_pend_in = cos_start ? fin.ovf : ovf_pend_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_dist_in  = out_dist_ff;
      out_zero_in  = out_zero_ff;
      out_ovf_in   = out_ovf_ff;
      if (cos_ack) begin
         out_valid_in = 1'b1;
         out_dist_in  = DIST_W'(cos_q);
         out_zero_in  = cos_zero;
         out_ovf_in   = ovf_pend_ff;
      end else if (l2_load) begin
         // squared l2 sum saturates at the field width
         out_valid_in = 1'b1;
         out_dist_in  = fin.sq[SQ_W-1] ? '1 : fin.sq[DIST_W-1:0];
         out_zero_in  = 1'b0;
         out_ovf_in   = fin.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff    <= 1'b0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         metric_ff    <= metric_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_last_ff  <= s1_last_in;
      s1_ovf_ff   <= s1_ovf_in;
      ovf_pend_ff <= ovf_pend_in;
      out_dist_ff <= out_dist_in;
      out_zero_ff <= out_zero_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(48-DIST_W){1'b0}}, out_dist_ff};
   assign rsp_tuser  = {out_ovf_ff, out_zero_ff};

endmodule
`default_nettype wire

FILE: rtl/core/vde_lane.sv
// vde_lane: one element pair, squared difference, product and both squares, registered
// depends on vde_pkg
`timescale 1ns / 1ps
`default_nettype none
module vde_lane
   import vde_pkg::*;
#(
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic                         enable,
   input  wire logic signed [ELEM_WIDTH-1:0] a,
   input  wire logic signed [ELEM_WIDTH-1:0] b,
   output logic [SQ_W-1:0]                   sq_ff,
   output logic [DOT_W-1:0]                  dot_ff,
   output logic [NORM_W-1:0]                 na_ff,
   output logic [NORM_W-1:0]                 nb_ff
);

   logic signed [ELEM_WIDTH:0]       diff;
   logic signed [2*ELEM_WIDTH+1:0]   dd;
   logic signed [2*ELEM_WIDTH-1:0]   ab, aa, bb;
   logic [SQ_W-1:0]                  sq_in;
   logic [DOT_W-1:0]                 dot_in;
   logic [NORM_W-1:0]                na_in, nb_in;

   always_comb begin
      diff   = (ELEM_WIDTH+1)'(a) - (ELEM_WIDTH+1)'(b);
      dd     = (2*ELEM_WIDTH+2)'(diff) * (2*ELEM_WIDTH+2)'(diff);
      ab     = (2*ELEM_WIDTH)'(a) * (2*ELEM_WIDTH)'(b);
      aa     = (2*ELEM_WIDTH)'(a) * (2*ELEM_WIDTH)'(a);
      bb     = (2*ELEM_WIDTH)'(b) * (2*ELEM_WIDTH)'(b);
      // dropped lanes add nothing
      sq_in  = enable ? SQ_W'(dd)   : '0;
      dot_in = enable ? DOT_W'(ab)  : '0;
      na_in  = enable ? NORM_W'(aa) : '0;
      nb_in  = enable ? NORM_W'(bb) : '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff  <= sq_in;
         dot_ff <= dot_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/vde_merge.sv
// vde_merge: adds the lane results into the running sums, hands out final sums on the last request
// depends on vde_pkg
`timescale 1ns / 1ps
`default_nettype none
module vde_merge
   import vde_pkg::*;
#(
   parameter int NUM_LANES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic              last,
   input  wire logic              ovf,
   input  wire logic [SQ_W-1:0]   lane_sq  [NUM_LANES],
   input  wire logic [DOT_W-1:0]  lane_dot [NUM_LANES],
   input  wire logic [NORM_W-1:0] lane_na  [NUM_LANES],
   input  wire logic [NORM_W-1:0] lane_nb  [NUM_LANES],
   output sums_type               fin
);

   sums_type acc_ff, acc_in;

   always_comb begin
      fin = acc_ff;
      fin.ovf = acc_ff.ovf | ovf;
      for (int i = 0; i < NUM_LANES; i++) begin
         fin.sq  = fin.sq  + lane_sq[i];
         fin.dot = fin.dot + lane_dot[i];
         fin.na  = fin.na  + lane_na[i];
         fin.nb  = fin.nb  + lane_nb[i];
      end
      acc_in = acc_ff;
      if (go) begin
         acc_in = last ? '0 : fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/vde_mul.sv
// vde_mul: shift-add multiplier, one multiplier bit per cycle
// depends on vde_pkg
`timescale 1ns / 1ps
`default_nettype none
module vde_mul
   import vde_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [MUL_A_W-1:0] a,
   input  wire logic [MUL_B_W-1:0] b,
   output logic                    done_ff,
   output logic [MUL_P_W-1:0]      acc_ff
);

   logic [MUL_P_W-1:0]   acc_in, a_sh_ff, a_sh_in;
   logic [MUL_B_W-1:0]   b_sh_ff, b_sh_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_sh_in = MUL_P_W'(a);
         b_sh_in = b;
         cnt_in  = MUL_CNT_W'(MUL_B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = a_sh_ff << 1;
         b_sh_in = b_sh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      cnt_ff  <= cnt_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/vde_cosine.sv
// vde_cosine: cosine distance by bisection on q, exact compare of squared terms
// depends on vde_pkg and vde_mul
`timescale 1ns / 1ps
`default_nettype none
module vde_cosine
   import vde_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire sums_type       sums,
   input  wire logic           res_ack,
   output logic                idle,
   output logic                res_valid,
   output logic [Q_W-1:0]      res_q,
   output logic                res_zero
);

   typedef enum logic [2:0] {
      S_IDLE, S_PROD, S_LSQ, S_SETUP, S_START, S_TEST, S_DECIDE, S_DONE
   } state_type;

   typedef enum logic [1:0] { PH_HI, PH_LO, PH_LOOP } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic                 dneg_ff, dneg_in;
   logic [DOT_W-1:0]     dmag_ff, dmag_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [LSQ_W-1:0]     lsq_ff, lsq_in;
   logic [Q_W-1:0]       q_ff, q_in, lo_ff, lo_in, hi_ff, hi_in, nlo, nhi;
   logic [Q_W:0]         mid_sum;
   logic [KK_W-1:0]      kk_ff, kk_in;
   logic                 early_ff, early_in, verdict_ff, verdict_in;
   logic                 zero_ff, zero_in;
   logic signed [K_W-1:0] k;
   logic [K_W-1:0]       kmag;
   logic [2*KM_W-1:0]    kk_full;
   logic                 mul_start, mul_done;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic                 lsq_ge, lsq_le;

   vde_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done_ff (mul_done),
      .acc_ff  (mul_p)
   );

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_q     = q_ff;
   assign res_zero  = zero_ff;

   always_comb begin
      k       = K_BASE - $signed({1'b0, q_ff, 1'b0});
      kmag    = k[K_W-1] ? K_W'(-k) : K_W'(k);
      kk_full = kmag[KM_W-1:0] * kmag[KM_W-1:0];
      lsq_ge  = lsq_ff >= LSQ_W'(mul_p);
      lsq_le  = lsq_ff <= LSQ_W'(mul_p);
      nlo     = verdict_ff ? q_ff : lo_ff;
      nhi     = verdict_ff ? hi_ff : q_ff;
      mid_sum = (Q_W+1)'(nlo) + (Q_W+1)'(nhi);
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      dneg_in    = dneg_ff;
      dmag_in    = dmag_ff;
      prod_in    = prod_ff;
      lsq_in     = lsq_ff;
      q_in       = q_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      kk_in      = kk_ff;
      early_in   = early_ff;
      verdict_in = verdict_ff;
      zero_in    = zero_ff;
      mul_start  = 1'b0;
      mul_a      = MUL_A_W'(prod_ff);
      mul_b      = MUL_B_W'(kk_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dneg_in = sums.dot[DOT_W-1];
               dmag_in = sums.dot[DOT_W-1] ? -sums.dot : sums.dot;
               if (sums.na == '0 || sums.nb == '0) begin
                  // degenerate vector: distance is exactly one
                  zero_in  = 1'b1;
                  q_in     = Q_ONE;
                  state_in = S_DONE;
               end else begin
                  zero_in   = 1'b0;
                  mul_start = 1'b1;
                  mul_a     = MUL_A_W'(sums.na);
                  mul_b     = MUL_B_W'(sums.nb);
                  state_in  = S_PROD;
               end
            end
         end
         S_PROD: begin
            if (mul_done) begin
               prod_in   = mul_p[PROD_W-1:0];
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(dmag_ff);
               mul_b     = MUL_B_W'(dmag_ff);
               state_in  = S_LSQ;
            end
         end
         S_LSQ: begin
            if (mul_done) begin
               lsq_in   = {mul_p[DSQ_W-1:0], {LSQ_SH{1'b0}}};
               phase_in = PH_HI;
               q_in     = Q_MAX;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            kk_in = kk_full[KK_W-1:0];
            if (!k[K_W-1] && (dneg_ff || dmag_ff == '0)) begin
               early_in   = 1'b1;
               verdict_in = 1'b1;
            end else if (k[K_W-1] && !dneg_ff) begin
               early_in   = 1'b1;
               verdict_in = 1'b0;
            end else begin
               early_in = 1'b0;
            end
            state_in = S_START;
         end
         S_START: begin
            if (early_ff) begin
               state_in = S_DECIDE;
            end else begin
               mul_start = 1'b1;
               state_in  = S_TEST;
            end
         end
         S_TEST: begin
            if (mul_done) begin
               verdict_in = dneg_ff ? lsq_ge : lsq_le;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (phase_ff)
               PH_HI: begin
                  if (verdict_ff) begin
                     state_in = S_DONE;
                  end else begin
                     phase_in = PH_LO;
                     q_in     = '0;
                     state_in = S_SETUP;
                  end
               end
               PH_LO: begin
                  if (!verdict_ff) begin
                     state_in = S_DONE;
                  end else begin
                     phase_in = PH_LOOP;
                     lo_in    = '0;
                     hi_in    = Q_MAX;
                     q_in     = Q_MAX >> 1;
                     state_in = S_SETUP;
                  end
               end
               PH_LOOP: begin
                  lo_in = nlo;
                  hi_in = nhi;
                  if (nhi - nlo > Q_W'(1)) begin
                     q_in     = mid_sum[Q_W:1];
                     state_in = S_SETUP;
                  end else begin
                     q_in     = nlo;
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HI;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      dneg_ff    <= dneg_in;
      dmag_ff    <= dmag_in;
      prod_ff    <= prod_in;
      lsq_ff     <= lsq_in;
      q_ff       <= q_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      kk_ff      <= kk_in;
      early_ff   <= early_in;
      verdict_ff <= verdict_in;
      zero_ff    <= zero_in;
   end

endmodule
`default_nettype wire
